/* hw/rtl/air_quality_beep_alarm_defines.svh */
// assertion macros for the air quality beep alarm
`ifndef AIR_QUALITY_BEEP_ALARM_DEFINES_SVH
`define AIR_QUALITY_BEEP_ALARM_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define AQBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AQBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AQBA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define AQBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/aqba_pkg.sv */
// types and constants shared by the air quality beep alarm
package aqba_pkg;

    localparam int DIV_DW = 17;
    localparam int DIV_VW = 10;
    localparam int DIV_CW = $clog2(DIV_DW);

    localparam logic [6:0] PERCENT_SCALE  = 7'd100;
    localparam logic [6:0] PERCENT_MAX    = 7'd100;
    localparam logic [8:0] PAUSE_LONG_MS  = 9'd450;
    localparam logic [8:0] PAUSE_SHORT_MS = 9'd120;
    localparam logic [8:0] PAUSE_SPAN_MS  = 9'd330;

    localparam logic [1:0] TONE_SILENT = 2'd0;
    localparam logic [1:0] TONE_LOW    = 2'd1;
    localparam logic [1:0] TONE_HIGH   = 2'd2;

    localparam logic [1:0] CFG_WARNING = 2'd0;
    localparam logic [1:0] CFG_DANGER  = 2'd1;
    localparam logic [1:0] CFG_BEEP    = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } t_div_rsp;

endpackage

/* hw/rtl/aqba_if.sv */
// input and output word channels of the air quality beep alarm
interface aqba_in_if;
    logic        valid;
    logic        ready;
    logic [9:0]  raw_sample;
    logic [31:0] time_ms;

    modport source (output valid, raw_sample, time_ms, input ready);
    modport sink (input valid, raw_sample, time_ms, output ready);
endinterface

interface aqba_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] quality_percent;
    logic       alert;
    logic       danger;
    logic [1:0] tone_code;

    modport source (output valid, quality_percent, alert, danger, tone_code, input ready);
    modport sink (input valid, quality_percent, alert, danger, tone_code, output ready);
endinterface

/* hw/rtl/aqba_div.sv */
// restoring divider, one quotient bit per cycle
`include "air_quality_beep_alarm_defines.svh"

module aqba_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aqba_pkg::t_div_req i_req,
    output aqba_pkg::t_div_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [aqba_pkg::DIV_CW-1:0] r_cnt;
    logic [aqba_pkg::DIV_DW-1:0] r_dvd;
    logic [aqba_pkg::DIV_VW-1:0] r_rem;
    logic [aqba_pkg::DIV_VW-1:0] r_div;

    logic [aqba_pkg::DIV_VW:0]   rem_sh;
    logic [aqba_pkg::DIV_VW:0]   rem_sub;
    logic                        ge;

    localparam logic [aqba_pkg::DIV_CW-1:0] LAST_STEP = aqba_pkg::DIV_CW'(aqba_pkg::DIV_DW - 1);

    always_comb begin
        rem_sh  = {r_rem, r_dvd[aqba_pkg::DIV_DW-1]};
        ge      = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_cnt  <= r_cnt + 1'b1;
                r_busy <= (r_cnt != LAST_STEP);
                r_done <= (r_cnt == LAST_STEP);
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[aqba_pkg::DIV_DW-2:0], ge};
            r_rem <= ge ? rem_sub[aqba_pkg::DIV_VW-1:0] : rem_sh[aqba_pkg::DIV_VW-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dvd;

    `AQBA_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_req.start, r_busy)
    `AQBA_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `AQBA_ASSERT_NEXT(a_last_done, i_clk, i_rst_n,
        r_busy && !i_req.start && r_cnt == LAST_STEP, r_done)

endmodule

/* hw/rtl/air_quality_beep_alarm.sv */
// air quality alarm: percent scaling, thresholds and beep sequencing
// i_in carries one word per sensor reading: raw_sample and time_ms.
// o_out returns one word per reading: quality_percent, alert, danger and
// tone_code (0 silent, 1 low, 2 high, as driven after this reading).
// thresholds and beep length are written on the cfg port; the user must write them only while idle
// (the block does not enforce this): index 0 warning percent, 1 danger percent, 2 beep length in ms.
// a word passes through S_SCALE, S_PREP and S_UPDATE on its way to o_out.valid, and also
// waits in S_DIV_P when a pause has to be worked out (alert, not danger, buzzer silent, warning below 100).
// the percent comes from a shift-and-add divide by 1023, registered in S_SCALE; the
// pause between beeps uses the 17-step divider.
// a new word is taken only once the last one has left S_UPDATE.
// i_in.ready is high only while the sequencer waits for a word.
// the result sits in an output register; the next word is taken while it
// waits, and the update stalls only if the old result is still not taken.
// reset silences the buzzer, clears the beep timer to 0 and loads the
// registers with warning 45, danger 75 and beep length 90 ms.
`include "air_quality_beep_alarm_defines.svh"

module air_quality_beep_alarm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    aqba_in_if.sink     i_in,
    aqba_out_if.source  o_out
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCALE  = 3'd1;
    localparam logic [2:0] S_PREP   = 3'd2;
    localparam logic [2:0] S_DIV_P  = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [6:0]  r_warn;
    logic [6:0]  r_danger;
    logic [15:0] r_beep;
    logic        r_sounding;
    logic [31:0] r_last;
    logic [1:0]  r_tone;
    logic [9:0]  r_raw;
    logic [31:0] r_time;
    logic [6:0]  r_q;
    logic [8:0]  r_pause;
    logic        r_out_valid;
    logic [6:0]  r_out_q;
    logic        r_out_alert;
    logic        r_out_danger;
    logic [1:0]  r_out_tone;

    aqba_pkg::t_div_req div_req;
    aqba_pkg::t_div_rsp div_rsp;

    logic        accept;
    logic        alert;
    logic        danger;
    logic        need_pause;
    logic [6:0]  q_diff;
    logic [6:0]  span;
    logic [31:0] elapsed;
    logic        out_free;
    logic        beep_over;
    logic        pause_over;
    logic [16:0] scaled;
    logic [16:0] q_sum;
    logic [6:0]  q_new;

    aqba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        accept     = i_in.valid && (r_state == S_IDLE);
        // divide by 1023 as (x + x/1024 + 1) / 1024, exact for x up to 102300
        scaled     = 17'(r_raw) * 17'(aqba_pkg::PERCENT_SCALE);
        q_sum      = scaled + 17'(scaled[16:10]) + 17'd1;
        q_new      = q_sum[16:10];
        alert      = r_q >= r_warn;
        danger     = r_q >= r_danger;
        need_pause = alert && !danger && !r_sounding && (r_warn < aqba_pkg::PERCENT_MAX);
        q_diff     = r_q - r_warn;
        span       = aqba_pkg::PERCENT_MAX - r_warn;
        elapsed    = r_time - r_last;
        beep_over  = elapsed >= {16'd0, r_beep};
        pause_over = elapsed >= {23'd0, r_pause};
        out_free   = !r_out_valid || o_out.ready;

        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        n_state          = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_state = S_PREP;
            end
            S_PREP: begin
                if (need_pause) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = aqba_pkg::DIV_DW'(q_diff) *
                                       aqba_pkg::DIV_DW'(aqba_pkg::PAUSE_SPAN_MS);
                    div_req.divisor  = aqba_pkg::DIV_VW'(span);
                    n_state          = S_DIV_P;
                end else begin
                    n_state = S_UPDATE;
                end
            end
            S_DIV_P: begin
                if (div_rsp.done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_warn      <= 7'd45;
            r_danger    <= 7'd75;
            r_beep      <= 16'd90;
            r_sounding  <= 1'b0;
            r_last      <= '0;
            r_tone      <= aqba_pkg::TONE_SILENT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    aqba_pkg::CFG_WARNING: r_warn   <= i_cfg_data[6:0];
                    aqba_pkg::CFG_DANGER:  r_danger <= i_cfg_data[6:0];
                    aqba_pkg::CFG_BEEP:    r_beep   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == S_UPDATE && out_free) begin
                r_out_valid <= 1'b1;
                if (!alert) begin
                    r_tone     <= aqba_pkg::TONE_SILENT;
                    r_sounding <= 1'b0;
                end else if (danger) begin
                    r_tone     <= aqba_pkg::TONE_HIGH;
                    r_sounding <= 1'b1;
                    r_last     <= r_time;
                end else if (r_sounding) begin
                    if (beep_over) begin
                        r_tone     <= aqba_pkg::TONE_SILENT;
                        r_sounding <= 1'b0;
                        r_last     <= r_time;
                    end
                end else if (pause_over) begin
                    r_tone     <= aqba_pkg::TONE_LOW;
                    r_sounding <= 1'b1;
                    r_last     <= r_time;
                end
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw  <= i_in.raw_sample;
            r_time <= i_in.time_ms;
        end
        if (r_state == S_SCALE) begin
            r_q <= q_new;
        end
        if (r_state == S_PREP) begin
            r_pause <= aqba_pkg::PAUSE_SHORT_MS;
        end
        if (r_state == S_DIV_P && div_rsp.done) begin
            r_pause <= aqba_pkg::PAUSE_LONG_MS - div_rsp.quotient[8:0];
        end
        if (r_state == S_UPDATE && out_free) begin
            r_out_q      <= r_q;
            r_out_alert  <= alert;
            r_out_danger <= danger;
            if (!alert) begin
                r_out_tone <= aqba_pkg::TONE_SILENT;
            end else if (danger) begin
                r_out_tone <= aqba_pkg::TONE_HIGH;
            end else if (r_sounding) begin
                r_out_tone <= beep_over ? aqba_pkg::TONE_SILENT : r_tone;
            end else begin
                r_out_tone <= pause_over ? aqba_pkg::TONE_LOW : r_tone;
            end
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.quality_percent = r_out_q;
    assign o_out.alert           = r_out_alert;
    assign o_out.danger          = r_out_danger;
    assign o_out.tone_code       = r_out_tone;

    `AQBA_ASSERT_SAME(a_silent_when_idle, i_clk, i_rst_n,
        !r_sounding, r_tone == aqba_pkg::TONE_SILENT)
    `AQBA_ASSERT_SAME(a_no_alert_silent, i_clk, i_rst_n,
        r_out_valid && !r_out_alert, r_out_tone == aqba_pkg::TONE_SILENT)
    `AQBA_ASSERT_SAME(a_div_done_in_wait, i_clk, i_rst_n,
        div_rsp.done, r_state == S_DIV_P)
    `AQBA_ASSERT_SAME(a_raw_matches_q, i_clk, i_rst_n,
        r_state == S_PREP, r_q <= aqba_pkg::PERCENT_MAX && (r_raw != 10'd0 || r_q == 7'd0))

endmodule
